[rtl/rtc_pkg.sv]
// Package with shared types, constants and codes for the redundancy tag cache.
package rtc_pkg;

    localparam int CACHE_LINES_DEF   = 16;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MERGE_MAX_DEF     = 8;
    localparam int ID_BITS_DEF       = 16;

    localparam int MODE_W   = 3;
    localparam int TAG_W    = 32;
    localparam int REQ_W    = 16;
    localparam int STATUS_W = 4;
    localparam int CFG_W    = 5;
    localparam int MLIM_W   = 4;
    localparam int TLIM_W   = 5;
    localparam int CNT_W    = 4;

    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FILL     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEANUP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESPONSE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_MISS     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_HIT      = 4'd1;
    localparam logic [STATUS_W-1:0] ST_PENDING  = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_STILL    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 4'd5;
    localparam logic [STATUS_W-1:0] ST_DONE     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_FULL     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 4'd8;

    localparam logic CFG_MERGE_LIMIT = 1'b0;
    localparam logic CFG_TABLE_LIMIT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic fill;
        logic alloc;
        logic response;
        logic release_inv;
        logic compact_step;
        logic compact_start;
        logic compact_end;
        logic rel_start;
        logic rel_step;
    } rtc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic owner_found;
        logic list_empty;
        logic table_full_cleanup;
        logic compact_done;
        logic rel_last;
    } rtc_stat_t;

endpackage

[rtl/rtc_datapath.sv]
// Datapath of the redundancy tag cache: tag store, miss table and merged id memory.
module rtc_datapath
    import rtc_pkg::*;
#(
    parameter int CACHE_LINES   = CACHE_LINES_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MERGE_MAX     = MERGE_MAX_DEF,
    parameter int ID_BITS       = ID_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [MODE_W-1:0]   in_mode,
    input  logic [TAG_W-1:0]    in_tag,
    input  logic [REQ_W-1:0]    in_id,
    input  rtc_cmd_t            cmd,
    output rtc_stat_t           stat,
    output logic [STATUS_W-1:0] res_status,
    output logic [REQ_W-1:0]    res_pair,
    output logic [REQ_W-1:0]    res_rel
);

    localparam int LW = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
    localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam int MW = (MERGE_MAX > 1) ? $clog2(MERGE_MAX) : 1;
    localparam int LSW = $clog2(MERGE_MAX + 1);
    localparam int DEPTH = TABLE_ENTRIES * MERGE_MAX;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [MLIM_W-1:0] merge_limit_reg;
    logic [TLIM_W-1:0] table_limit_reg;

    logic [MODE_W-1:0] mode_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [ID_BITS-1:0] id_reg;

    logic [CACHE_LINES-1:0] line_valid_reg;
    logic [TAG_W-1:0]       line_tag_reg [CACHE_LINES];
    logic [LW-1:0]          victim_reg;

    logic [TABLE_ENTRIES-1:0] ev_reg;
    logic [TABLE_ENTRIES-1:0] ec_reg;
    logic [TAG_W-1:0]         et_reg  [TABLE_ENTRIES];
    logic [ID_BITS-1:0]       eo_reg  [TABLE_ENTRIES];
    logic [CNT_W-1:0]         en_reg  [TABLE_ENTRIES];
    logic [LSW-1:0]           el_reg  [TABLE_ENTRIES];
    logic [UW-1:0]            used_reg;

    logic [ID_BITS-1:0] mem [DEPTH];
    logic [ID_BITS-1:0] mem_rd_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [ID_BITS-1:0]  pair_reg;

    // Compaction: read and write slot indexes and the id position within the slot being moved.
    logic [UW-1:0] crd_reg;
    logic [UW-1:0] cwr_reg;
    logic [MW:0]   csub_reg;

    // Release: slot and position.
    logic [EW-1:0]  rslot_reg;
    logic [LSW-1:0] rpos_reg;
    logic [LSW-1:0] rlen_reg;

    logic [MLIM_W-1:0] eff_merge;
    logic [UW-1:0]     eff_table;
    logic              line_hit;
    logic              free_found;
    logic [LW-1:0]     free_idx;
    logic              ent_found;
    logic [EW-1:0]     ent_idx;
    logic              own_found;
    logic [EW-1:0]     own_idx;
    logic              can_merge;
    logic              exec_cmd;

    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [ID_BITS-1:0] mem_wdata;

    function automatic logic [AW-1:0] maddr(input logic [EW-1:0] s, input logic [MW-1:0] p);
        logic [AW+EW:0] a;
        a = (AW+EW+1)'(s) * (AW+EW+1)'(MERGE_MAX) + (AW+EW+1)'(p);
        return a[AW-1:0];
    endfunction

    assign exec_cmd = cmd.lookup || cmd.fill || cmd.alloc || cmd.response
                      || cmd.compact_start || cmd.rel_start;

    always_comb
    begin
        if (32'(merge_limit_reg) < MERGE_MAX)
            eff_merge = merge_limit_reg;
        else
            eff_merge = MLIM_W'(MERGE_MAX);
        if (32'(table_limit_reg) < 32'(TABLE_ENTRIES))
            eff_table = UW'(table_limit_reg);
        else
            eff_table = UW'(TABLE_ENTRIES);
    end

    always_comb
    begin
        line_hit   = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < CACHE_LINES; i++)
        begin
            if (line_valid_reg[i] && line_tag_reg[i] == tag_reg)
                line_hit = 1'b1;
            if (!line_valid_reg[i] && !free_found)
            begin
                free_found = 1'b1;
                free_idx   = LW'(i);
            end
        end
    end

    always_comb
    begin
        ent_found = 1'b0;
        ent_idx   = '0;
        own_found = 1'b0;
        own_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (UW'(i) < used_reg && ev_reg[i] && et_reg[i] == tag_reg)
            begin
                ent_found = 1'b1;
                ent_idx   = EW'(i);
            end
            if (UW'(i) < used_reg && ev_reg[i] && eo_reg[i] == id_reg)
            begin
                own_found = 1'b1;
                own_idx   = EW'(i);
            end
        end
        can_merge = ent_found && !ec_reg[ent_idx] && en_reg[ent_idx] < eff_merge
                    && 32'(el_reg[ent_idx]) < 32'(MERGE_MAX);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = id_reg;
        if (cmd.lookup && !line_hit && can_merge)
        begin
            mem_we    = 1'b1;
            mem_waddr = maddr(ent_idx, MW'(el_reg[ent_idx]));
        end
        else if (cmd.alloc && used_reg < eff_table)
        begin
            mem_we    = 1'b1;
            mem_waddr = maddr(EW'(used_reg), '0);
        end
        else if (cmd.compact_step && csub_reg != '0)
        begin
            mem_we    = 1'b1;
            mem_waddr = maddr(EW'(cwr_reg), MW'(csub_reg - 1'b1));
            mem_wdata = mem_rd_reg;
        end
        if (cmd.compact_step)
            mem_raddr = maddr(EW'(crd_reg), MW'(csub_reg));
        else if (cmd.rel_start)
            mem_raddr = maddr(own_idx, '0);
        else
            mem_raddr = maddr(rslot_reg, MW'(rpos_reg));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rd_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        stat.owner_found        = own_found;
        stat.list_empty         = (el_reg[own_idx] == '0);
        stat.table_full_cleanup = (used_reg >= eff_table);
        stat.compact_done       = (crd_reg >= used_reg) || (32'(crd_reg) >= TABLE_ENTRIES);
        stat.rel_last           = (rpos_reg + 1'b1 >= rlen_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_limit_reg <= MLIM_W'(4);
            table_limit_reg <= TLIM_W'(16);
            line_valid_reg  <= '0;
            victim_reg      <= '0;
            ev_reg          <= '0;
            ec_reg          <= '0;
            used_reg        <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                en_reg[i] <= '0;
                el_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_MERGE_LIMIT)
                merge_limit_reg <= cfg_wdata[MLIM_W-1:0];
            if (cfg_we && cfg_index == CFG_TABLE_LIMIT)
                table_limit_reg <= cfg_wdata;
            if (cmd.lookup && !line_hit && can_merge)
            begin
                el_reg[ent_idx] <= el_reg[ent_idx] + 1'b1;
                en_reg[ent_idx] <= en_reg[ent_idx] + 1'b1;
                if (en_reg[ent_idx] + 1'b1 == eff_merge)
                    ec_reg[ent_idx] <= 1'b1;
            end
            if (cmd.fill)
            begin
                if (free_found)
                begin
                    line_valid_reg[free_idx] <= 1'b1;
                end
                else
                begin
                    line_valid_reg[victim_reg] <= 1'b1;
                    victim_reg <= (32'(victim_reg) == CACHE_LINES - 1) ? '0
                                                                      : victim_reg + 1'b1;
                end
            end
            if (cmd.alloc && used_reg < eff_table)
            begin
                ev_reg[EW'(used_reg)] <= 1'b1;
                ec_reg[EW'(used_reg)] <= 1'b0;
                en_reg[EW'(used_reg)] <= CNT_W'(1);
                el_reg[EW'(used_reg)] <= LSW'(1);
                used_reg              <= used_reg + 1'b1;
            end
            if (cmd.response && own_found)
            begin
                en_reg[own_idx] <= en_reg[own_idx] - 1'b1;
                if (en_reg[own_idx] == CNT_W'(1))
                    ev_reg[own_idx] <= 1'b0;
            end
            if (cmd.release_inv && own_found)
                ev_reg[own_idx] <= 1'b0;
            if (cmd.compact_step && csub_reg == '0)
            begin
                if (ev_reg[EW'(crd_reg)])
                begin
                    ev_reg[EW'(cwr_reg)] <= 1'b1;
                    ec_reg[EW'(cwr_reg)] <= ec_reg[EW'(crd_reg)];
                    en_reg[EW'(cwr_reg)] <= en_reg[EW'(crd_reg)];
                    el_reg[EW'(cwr_reg)] <= el_reg[EW'(crd_reg)];
                end
            end
            if (cmd.compact_end)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (UW'(i) >= cwr_reg)
                    begin
                        ev_reg[i] <= 1'b0;
                        ec_reg[i] <= 1'b0;
                        en_reg[i] <= '0;
                        el_reg[i] <= '0;
                    end
                end
                used_reg <= cwr_reg;
            end
        end
    end

    // Compaction skips a dead source slot and moves a live one: its entry fields, then every id position in turn.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crd_reg  <= '0;
            cwr_reg  <= '0;
            csub_reg <= '0;
            rslot_reg <= '0;
            rpos_reg  <= '0;
            rlen_reg  <= '0;
        end
        else
        begin
            if (cmd.compact_start)
            begin
                crd_reg  <= '0;
                cwr_reg  <= '0;
                csub_reg <= '0;
            end
            else if (cmd.compact_step)
            begin
                if (!ev_reg[EW'(crd_reg)] && csub_reg == '0)
                begin
                    crd_reg <= crd_reg + 1'b1;
                end
                else if (32'(csub_reg) == MERGE_MAX)
                begin
                    csub_reg <= '0;
                    crd_reg  <= crd_reg + 1'b1;
                    cwr_reg  <= cwr_reg + 1'b1;
                end
                else
                begin
                    csub_reg <= csub_reg + 1'b1;
                end
            end
            if (cmd.rel_start)
            begin
                rslot_reg <= own_idx;
                rpos_reg  <= '0;
                rlen_reg  <= el_reg[own_idx];
            end
            else if (cmd.rel_step)
            begin
                rpos_reg <= rpos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            tag_reg  <= in_tag;
            id_reg   <= ID_BITS'(in_id);
        end
        if (cmd.fill)
            line_tag_reg[free_found ? free_idx : victim_reg] <= tag_reg;
        if (cmd.alloc && used_reg < eff_table)
        begin
            et_reg[EW'(used_reg)] <= tag_reg;
            eo_reg[EW'(used_reg)] <= id_reg;
        end
        if (cmd.compact_step && csub_reg == '0 && ev_reg[EW'(crd_reg)])
        begin
            et_reg[EW'(cwr_reg)] <= et_reg[EW'(crd_reg)];
            eo_reg[EW'(cwr_reg)] <= eo_reg[EW'(crd_reg)];
        end
        if (exec_cmd)
        begin
            unique case (mode_reg)
                MODE_LOOKUP:
                begin
                    if (line_hit)
                    begin
                        status_reg <= ST_HIT;
                        pair_reg   <= '0;
                    end
                    else if (can_merge)
                    begin
                        status_reg <= ST_PENDING;
                        pair_reg   <= eo_reg[ent_idx];
                    end
                    else
                    begin
                        status_reg <= ST_MISS;
                        pair_reg   <= '0;
                    end
                end
                MODE_ALLOC:
                begin
                    status_reg <= (used_reg < eff_table) ? ST_DONE : ST_FULL;
                    pair_reg   <= '0;
                end
                MODE_RESPONSE:
                begin
                    pair_reg <= '0;
                    if (!own_found)
                        status_reg <= ST_NOMATCH;
                    else if (en_reg[own_idx] == CNT_W'(1))
                        status_reg <= ST_FINISHED;
                    else
                        status_reg <= ST_STILL;
                end
                MODE_RELEASE:
                begin
                    status_reg <= (own_found && el_reg[own_idx] != '0) ? ST_RELEASED
                                                                       : ST_NOMATCH;
                    pair_reg   <= '0;
                end
                default:
                begin
                    status_reg <= ST_DONE;
                    pair_reg   <= '0;
                end
            endcase
        end
    end

    assign res_status = status_reg;
    assign res_pair   = REQ_W'(pair_reg);
    assign res_rel    = (status_reg == ST_RELEASED) ? REQ_W'(mem_rd_reg) : '0;

endmodule

[rtl/rtc_ctrl.sv]
// Controller state machine of the redundancy tag cache.
module rtc_ctrl
    import rtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] in_mode,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_last,
    output rtc_cmd_t          cmd,
    input  rtc_stat_t         stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COMPACT,
        S_REL_READ,
        S_OUT,
        S_REL_OUT
    } state_t;

    state_t            state_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              out_valid_reg;
    logic              last_reg;

    logic in_fire;
    logic out_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        cmd = '0;
        cmd.capture = in_fire;
        if (state_reg == S_EXEC)
        begin
            cmd.lookup   = (mode_reg == MODE_LOOKUP);
            cmd.fill     = (mode_reg == MODE_FILL);
            cmd.alloc    = (mode_reg == MODE_ALLOC);
            cmd.response = (mode_reg == MODE_RESPONSE);
            cmd.compact_start = (mode_reg == MODE_CLEANUP);
            cmd.rel_start = (mode_reg == MODE_RELEASE);
            cmd.release_inv = (mode_reg == MODE_RELEASE);
        end
        if (state_reg == S_COMPACT)
        begin
            cmd.compact_step = !stat.compact_done;
            cmd.compact_end  = stat.compact_done;
        end
        if (state_reg == S_REL_OUT && out_fire && !last_reg)
            cmd.rel_step = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_LOOKUP;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && in_mode <= MODE_RELEASE)
                    begin
                        mode_reg  <= in_mode;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (mode_reg == MODE_CLEANUP && stat.table_full_cleanup)
                        state_reg <= S_COMPACT;
                    else if (mode_reg == MODE_RELEASE && stat.owner_found
                             && !stat.list_empty)
                        state_reg <= S_REL_READ;
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        last_reg      <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_COMPACT:
                begin
                    if (stat.compact_done)
                    begin
                        out_valid_reg <= 1'b1;
                        last_reg      <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_REL_READ:
                begin
                    out_valid_reg <= 1'b1;
                    last_reg      <= stat.rel_last;
                    state_reg     <= S_REL_OUT;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        out_valid_reg <= 1'b0;
                        last_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_REL_OUT:
                begin
                    if (out_fire)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            last_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_REL_READ;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("result offered while idle");
    a_last_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |-> out_valid || state_reg == S_REL_READ)
        else $error("last flag without a result");
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_reg) |=> in_ready)
        else $error("not idle after final result");

endmodule

[rtl/redundancy_tag_cache_with_mshr_merge.sv]
// Top level of the redundancy tag cache with miss-table merging.
// One transaction is taken at a time; the next one is accepted in the cycle after the final
// result of the previous one is taken. Lookup, fill, allocate, response, release of an unknown
// owner or of an empty id list and cleanup with the table not full give a single registered
// result; a cleanup with a full table walks the table, skips dead slots and moves each live
// entry with its id list through the merged id memory one id per cycle, then closes. A release
// gives one result per merged id; each id comes from the registered memory read, and the next
// one is read after the previous one is taken.
module redundancy_tag_cache_with_mshr_merge
    import rtc_pkg::*;
#(
    parameter int CACHE_LINES   = CACHE_LINES_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MERGE_MAX     = MERGE_MAX_DEF,
    parameter int ID_BITS       = ID_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [TAG_W-1:0]    tag,
    input  logic [REQ_W-1:0]    request_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [REQ_W-1:0]    pair_id,
    output logic [REQ_W-1:0]    released_id,
    output logic                last
);

    rtc_cmd_t  cmd;
    rtc_stat_t stat;

    rtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_mode   (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (last),
        .cmd       (cmd),
        .stat      (stat)
    );

    rtc_datapath #(
        .CACHE_LINES   (CACHE_LINES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MERGE_MAX     (MERGE_MAX),
        .ID_BITS       (ID_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_mode    (mode),
        .in_tag     (tag),
        .in_id      (request_id),
        .cmd        (cmd),
        .stat       (stat),
        .res_status (status),
        .res_pair   (pair_id),
        .res_rel    (released_id)
    );

endmodule
